FILE: rtl/core/sbld_pkg.sv
// Shared constants for the spectrum bar level display.
// Field widths, register indexes and reset values; used by every file in rtl/core.
package sbld_pkg;

    // Widths fixed by the stream and register fields.
    localparam int CFG_W       = 16;
    localparam int ENERGY_W    = 16;
    localparam int SUM_W       = 24;
    localparam int FPOS_W      = 7;
    localparam int LEVEL_W     = 4;
    localparam int BIN_IDX_W   = 6;
    localparam int FIRST_COL_W = 7;
    localparam int COL_CNT_W   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 1;

    // Default geometry.
    localparam int DEF_NUM_BINS        = 43;
    localparam int DEF_FRAME_COUNT     = 98;
    localparam int DEF_DISPLAY_COLUMNS = 99;
    localparam int DEF_NUM_LEVELS      = 9;

    // Register reset values: -5.0 and 2.0 in Q4.12.
    localparam logic signed [CFG_W-1:0] FLOOR_RESET   = -16'sd20480;
    localparam logic signed [CFG_W-1:0] CEILING_RESET = 16'sd8192;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_FLOOR   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_CEILING = 1'b1;

    // Saturation bounds of a bin sum.
    localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;

endpackage

FILE: rtl/core/sbld_level_unit.sv
// Level quantizer: floor(TOP*num/den) clamped to 0..TOP by repeated subtraction.
// Depends on sbld_pkg for the level width.
module sbld_level_unit #(
    parameter int NUM_W      = 26,
    parameter int DEN_W      = 26,
    parameter int NUM_LEVELS = sbld_pkg::DEF_NUM_LEVELS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [NUM_W-1:0]         num,
    input  logic signed [DEN_W-1:0]         den,
    output logic                            done,
    output logic [sbld_pkg::LEVEL_W-1:0]    level
);

    localparam int REM_W = NUM_W + sbld_pkg::LEVEL_W;
    localparam logic [sbld_pkg::LEVEL_W-1:0] TOP = sbld_pkg::LEVEL_W'(NUM_LEVELS - 1);

    typedef enum logic {
        U_IDLE,
        U_RUN
    } ustate_t;

    ustate_t                          state_reg;
    logic                             done_reg;
    logic [sbld_pkg::LEVEL_W-1:0]     q_reg;
    logic [REM_W-1:0]                 rem_reg;
    logic [REM_W-1:0]                 den_reg;
    logic [REM_W-1:0]                 scaled_num;
    logic                             rem_below;

    // Scaled numerator; only used when the numerator is not negative.
    assign scaled_num = REM_W'($unsigned(num)) * REM_W'(TOP);
    assign rem_below  = rem_reg < den_reg;

    // Sequencer: one compare and subtract per cycle, at most TOP steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            q_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE: begin
                    if (start) begin
                        if (den <= 0) begin
                            q_reg    <= (num >= 0) ? TOP : '0;
                            done_reg <= 1'b1;
                        end else if (num < 0) begin
                            q_reg    <= '0;
                            done_reg <= 1'b1;
                        end else begin
                            q_reg     <= '0;
                            rem_reg   <= scaled_num;
                            den_reg   <= REM_W'($unsigned(den));
                            state_reg <= U_RUN;
                        end
                    end
                end
                U_RUN: begin
                    if (q_reg == TOP || rem_below) begin
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end else begin
                        rem_reg <= rem_reg - den_reg;
                        q_reg   <= q_reg + 1'b1;
                    end
                end
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign level = q_reg;

endmodule

FILE: rtl/core/spectrum_bar_level_display.sv
// Spectrum bar level display top level: bin accumulator memory, run sequencer, column mapping.
// Depends on sbld_pkg and sbld_level_unit.
//
// Usage: the slave stream carries one signed Q4.12 log energy per transaction in
// s_tdata[15:0], frame by frame and bin by bin within a frame; s_tlast marks the
// final value of the spectrogram. The first frame overwrites each bin sum and later
// frames add to it with saturation to 24 bits. After the final value the master
// stream returns one transaction per bin, bins in ascending order, with m_tlast on
// the last bin. The floor and ceiling registers are written through cfg_we,
// cfg_addr and cfg_wdata while no run is in progress.
// Input: each value gets a memory read, then the add and write back of the same
// bin sum; s_tready is low during the write back, so no value is taken before it.
// Each result goes through a memory read, the numerator subtract, and the level
// quantizer, which subtracts the scaled range once per cycle for up to NUM_LEVELS-1
// steps, and may wait on receiver stalls. No input is taken while results are being
// produced; s_tready returns the cycle after the last result is taken. A stalled
// result holds on the master side until m_tready is high.
// Reset returns the run position to the start of the first frame and the
// registers to -5.0 and 2.0; the bin sums are not cleared, and each one is
// overwritten when the first frame of a run reaches its bin.
module spectrum_bar_level_display #(
    parameter int NUM_BINS        = sbld_pkg::DEF_NUM_BINS,
    parameter int FRAME_COUNT     = sbld_pkg::DEF_FRAME_COUNT,
    parameter int DISPLAY_COLUMNS = sbld_pkg::DEF_DISPLAY_COLUMNS,
    parameter int NUM_LEVELS      = sbld_pkg::DEF_NUM_LEVELS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sbld_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] energy
    input  logic                                s_tlast,   // last_value
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sbld_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [5:0] bin_index, [9:6] level,
                                                           // [16:10] first_column,
                                                           // [18:17] column_count, [23:19] zero
    output logic                                m_tlast,   // last_bin
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [sbld_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [sbld_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int F_W    = $clog2(FRAME_COUNT + 1);
    localparam int BASE_W = sbld_pkg::CFG_W + F_W + 1;
    localparam int NUM_W  = ((sbld_pkg::SUM_W > BASE_W) ? sbld_pkg::SUM_W : BASE_W) + 1;
    localparam int DIFF_W = sbld_pkg::CFG_W + 1;
    localparam int DEN_W  = DIFF_W + F_W + 1;
    localparam int COL_W  = $clog2(DISPLAY_COLUMNS + 1);
    localparam int R_W    = $clog2(2 * NUM_BINS);
    localparam int COL_QD = DISPLAY_COLUMNS / NUM_BINS;
    localparam int COL_RD = DISPLAY_COLUMNS % NUM_BINS;
    localparam int PAD_W  = sbld_pkg::OUT_TDATA_W - sbld_pkg::BIN_IDX_W - sbld_pkg::LEVEL_W
                            - sbld_pkg::FIRST_COL_W - sbld_pkg::COL_CNT_W;

    localparam logic [BIN_W-1:0]           LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [sbld_pkg::FPOS_W-1:0] FPOS_MAX = '1;
    localparam logic signed [F_W:0]        FRAMES_S = (F_W + 1)'(FRAME_COUNT);
    localparam logic [COL_W-1:0]           COL_MAX  = COL_W'(DISPLAY_COLUMNS);
    localparam logic [R_W-1:0]             R_NB     = R_W'(NUM_BINS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ACC,
        ST_FETCH,
        ST_NUM,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Control and payload registers.
    state_t                                 state_reg;
    logic [BIN_W-1:0]                       bin_pos_reg;
    logic [sbld_pkg::FPOS_W-1:0]            frame_pos_reg;
    logic                                   last_reg;
    logic signed [sbld_pkg::ENERGY_W-1:0]   energy_reg;
    logic signed [sbld_pkg::CFG_W-1:0]      floor_reg;
    logic signed [sbld_pkg::CFG_W-1:0]      ceiling_reg;
    logic [BIN_W-1:0]                       k_reg;
    logic [COL_W-1:0]                       col_q_reg;
    logic [R_W-1:0]                         col_r_reg;
    logic signed [BASE_W-1:0]               base_reg;
    logic signed [DEN_W-1:0]                den_reg;
    logic signed [NUM_W-1:0]                num_reg;
    logic                                   m_tvalid_reg;
    logic [sbld_pkg::OUT_TDATA_W-1:0]       m_tdata_reg;
    logic                                   m_tlast_reg;

    // Bin sum memory and its registered read port.
    logic signed [sbld_pkg::SUM_W-1:0]      bin_sums [NUM_BINS];
    logic signed [sbld_pkg::SUM_W-1:0]      rd_reg;

    logic                                   s_accept;
    logic                                   m_accept;
    logic                                   mem_re;
    logic                                   mem_we;
    logic [BIN_W-1:0]                       mem_raddr;
    logic signed [sbld_pkg::SUM_W:0]        acc_wide;
    logic signed [sbld_pkg::SUM_W-1:0]      acc_sat;
    logic signed [sbld_pkg::SUM_W-1:0]      sum_next;
    logic signed [DIFF_W-1:0]               range_diff;
    logic signed [BASE_W-1:0]               base_next;
    logic signed [DEN_W-1:0]                den_next;
    logic [R_W-1:0]                         r_sum;
    logic                                   r_carry;
    logic [COL_W-1:0]                       col_q_next;
    logic [R_W-1:0]                         col_r_next;
    logic [COL_W-1:0]                       first_col;
    logic [COL_W-1:0]                       end_col;
    logic [COL_W-1:0]                       col_span;
    logic                                   lvl_start;
    logic                                   lvl_done;
    logic [sbld_pkg::LEVEL_W-1:0]           lvl_value;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid_reg && m_tready;

    // Saturating accumulate of the incoming value onto the stored sum; the first frame takes the value as it is.
    always_comb begin
        acc_wide = (sbld_pkg::SUM_W + 1)'(rd_reg) + (sbld_pkg::SUM_W + 1)'(energy_reg);
        if (acc_wide > sbld_pkg::SUM_MAX) begin
            acc_sat = sbld_pkg::SUM_W'(sbld_pkg::SUM_MAX);
        end else if (acc_wide < sbld_pkg::SUM_MIN) begin
            acc_sat = sbld_pkg::SUM_W'(sbld_pkg::SUM_MIN);
        end else begin
            acc_sat = sbld_pkg::SUM_W'(acc_wide);
        end
        sum_next = (frame_pos_reg == '0) ? sbld_pkg::SUM_W'(energy_reg) : acc_sat;
    end

    // Level scaling terms: F*floor and F*(ceiling-floor).
    always_comb begin
        range_diff = DIFF_W'(ceiling_reg) - DIFF_W'(floor_reg);
        base_next  = BASE_W'(FRAMES_S) * BASE_W'(floor_reg);
        den_next   = DEN_W'(FRAMES_S) * DEN_W'(range_diff);
    end

    // Column mapping: first column of bin k is ceil(k*COLUMNS/BINS), tracked as
    // quotient and remainder and stepped by COLUMNS for each bin.
    always_comb begin
        r_sum      = col_r_reg + R_W'(COL_RD);
        r_carry    = r_sum >= R_NB;
        col_r_next = r_carry ? (r_sum - R_NB) : r_sum;
        col_q_next = col_q_reg + COL_W'(COL_QD) + COL_W'(r_carry);
        first_col  = (col_q_reg > COL_MAX) ? COL_MAX : col_q_reg;
        end_col    = (col_q_next > COL_MAX) ? COL_MAX : col_q_next;
        col_span   = end_col - first_col;
    end

    // Memory port control.
    assign mem_re    = s_accept || (state_reg == ST_FETCH);
    assign mem_we    = (state_reg == ST_ACC);
    assign mem_raddr = (state_reg == ST_LOAD) ? bin_pos_reg : k_reg;
    assign lvl_start = (state_reg == ST_START);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_sums[bin_pos_reg] <= sum_next;
        end
        if (mem_re) begin
            rd_reg <= bin_sums[mem_raddr];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= sbld_pkg::FLOOR_RESET;
            ceiling_reg <= sbld_pkg::CEILING_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sbld_pkg::CFG_LEVEL_FLOOR:   floor_reg   <= cfg_wdata;
                sbld_pkg::CFG_LEVEL_CEILING: ceiling_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Run sequencer: load values, then produce one result per bin.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            bin_pos_reg   <= '0;
            frame_pos_reg <= '0;
            k_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        energy_reg <= s_tdata[sbld_pkg::ENERGY_W-1:0];
                        last_reg   <= s_tlast;
                        state_reg  <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (last_reg) begin
                        bin_pos_reg   <= '0;
                        frame_pos_reg <= '0;
                        k_reg         <= '0;
                        col_q_reg     <= '0;
                        col_r_reg     <= R_W'(NUM_BINS - 1);
                        state_reg     <= ST_FETCH;
                    end else begin
                        if (bin_pos_reg == LAST_BIN) begin
                            bin_pos_reg <= '0;
                            if (frame_pos_reg != FPOS_MAX) begin
                                frame_pos_reg <= frame_pos_reg + 1'b1;
                            end
                        end else begin
                            bin_pos_reg <= bin_pos_reg + 1'b1;
                        end
                        state_reg <= ST_LOAD;
                    end
                end
                ST_FETCH: begin
                    base_reg  <= base_next;
                    den_reg   <= den_next;
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    num_reg   <= NUM_W'(rd_reg) - NUM_W'(base_reg);
                    state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (lvl_done) begin
                        m_tdata_reg  <= {PAD_W'(0),
                                         col_span[sbld_pkg::COL_CNT_W-1:0],
                                         sbld_pkg::FIRST_COL_W'(first_col),
                                         lvl_value,
                                         sbld_pkg::BIN_IDX_W'(k_reg)};
                        m_tlast_reg  <= (k_reg == LAST_BIN);
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_accept) begin
                        m_tvalid_reg <= 1'b0;
                        if (k_reg == LAST_BIN) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            col_q_reg <= col_q_next;
                            col_r_reg <= col_r_next;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    sbld_level_unit #(
        .NUM_W      (NUM_W),
        .DEN_W      (DEN_W),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_level (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lvl_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (lvl_done),
        .level   (lvl_value)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The block never takes input while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // Offered levels stay within the display range.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:6] <= sbld_pkg::LEVEL_W'(NUM_LEVELS - 1)))
        else $error("level out of range");

    // Input reopens right after the final bin result is taken.
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after the last bin");

    // A result appears only after the level unit has finished.
    a_result_after_level: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(lvl_done))
        else $error("result offered without a level");

endmodule

FILE: sim/tb_spectrum_bar_level_display.sv
// Testbench for spectrum_bar_level_display: streams spectrogram runs and checks every bin result.
// Depends on sbld_pkg and the RTL in rtl/core; predicts sums, levels and column spans itself.
module tb_spectrum_bar_level_display;

    localparam int NB              = sbld_pkg::DEF_NUM_BINS;
    localparam int NF              = sbld_pkg::DEF_FRAME_COUNT;
    localparam int NCOL            = sbld_pkg::DEF_DISPLAY_COLUMNS;
    localparam int TOP_LEVEL       = sbld_pkg::DEF_NUM_LEVELS - 1;
    localparam int FRAME_POS_MAX   = (1 << sbld_pkg::FPOS_W) - 1;
    localparam int CROSS_RUN       = NB + 8;
    localparam int PHASE_ITEMS     = 25;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 10;

    // One expected bin result, unpacked into its fields.
    typedef struct {
        logic [sbld_pkg::BIN_IDX_W-1:0]   bin;
        logic [sbld_pkg::LEVEL_W-1:0]     level;
        logic [sbld_pkg::FIRST_COL_W-1:0] first_col;
        logic [sbld_pkg::COL_CNT_W-1:0]   col_count;
        logic                             last_bin;
    } bar_result_t;

    // Level predictor: bin sums, run position, level registers and the queue of
    // expected bin results.
    class bar_level_scoreboard;
        int          bin_sum [NB];
        int          frame_pos;
        int          bin_pos;
        int          floor_q;
        int          ceiling_q;
        int          mismatches;
        bar_result_t expected_bars [$];

        function new();
            foreach (bin_sum[k]) bin_sum[k] = 0;
            frame_pos  = 0;
            bin_pos    = 0;
            floor_q    = int'(sbld_pkg::FLOOR_RESET);
            ceiling_q  = int'(sbld_pkg::CEILING_RESET);
            mismatches = 0;
        endfunction

        function void write_register(logic [sbld_pkg::CFG_ADDR_W-1:0] idx,
                                     logic [sbld_pkg::CFG_W-1:0] value);
            if (idx == sbld_pkg::CFG_LEVEL_FLOOR) begin
                floor_q = int'($signed(value));
            end else begin
                ceiling_q = int'($signed(value));
            end
        endfunction

        // First display column of a bin: ceil(b * columns / bins), capped at the column count.
        function int first_column(int b);
            int c;
            c = (b * NCOL + NB - 1) / NB;
            if (c > NCOL) c = NCOL;
            return c;
        endfunction

        // Quantized level of a bin sum against the scaled floor and ceiling.
        function int bar_level(int s);
            longint num;
            longint den;
            longint q;
            num = longint'(s) - longint'(NF) * floor_q;
            den = longint'(NF) * (longint'(ceiling_q) - floor_q);
            if (den <= 0) return (num >= 0) ? TOP_LEVEL : 0;
            if (num < 0) return 0;
            q = (longint'(TOP_LEVEL) * num) / den;
            if (q > TOP_LEVEL) q = TOP_LEVEL;
            return int'(q);
        endfunction

        // Accumulate one energy value; on the final value queue one result per bin.
        function void note_input(logic [sbld_pkg::ENERGY_W-1:0] energy, logic last);
            longint      acc;
            int          f0;
            int          f1;
            bar_result_t r;
            if (frame_pos == 0) begin
                bin_sum[bin_pos] = int'($signed(energy));
            end else begin
                acc = longint'(bin_sum[bin_pos]) + longint'($signed(energy));
                if (acc > longint'(sbld_pkg::SUM_MAX)) acc = longint'(sbld_pkg::SUM_MAX);
                if (acc < longint'(sbld_pkg::SUM_MIN)) acc = longint'(sbld_pkg::SUM_MIN);
                bin_sum[bin_pos] = int'(acc);
            end
            bin_pos++;
            if (bin_pos >= NB) begin
                bin_pos = 0;
                if (frame_pos < FRAME_POS_MAX) frame_pos++;
            end
            if (!last) return;
            for (int k = 0; k < NB; k++) begin
                f0          = first_column(k);
                f1          = first_column(k + 1);
                r.bin       = sbld_pkg::BIN_IDX_W'(k);
                r.level     = sbld_pkg::LEVEL_W'(bar_level(bin_sum[k]));
                r.first_col = sbld_pkg::FIRST_COL_W'(f0);
                r.col_count = sbld_pkg::COL_CNT_W'(f1 - f0);
                r.last_bin  = (k == NB - 1);
                expected_bars.push_back(r);
            end
            frame_pos = 0;
            bin_pos   = 0;
        endfunction

        // Compare one result transaction with the oldest expected bin result.
        function void check_result(logic [sbld_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
            bar_result_t want;
            if (expected_bars.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected bin result tdata=%h tlast=%b", tdata, tlast);
                return;
            end
            want = expected_bars.pop_front();
            if (tdata[5:0] !== want.bin || tdata[9:6] !== want.level ||
                tdata[16:10] !== want.first_col || tdata[18:17] !== want.col_count ||
                tlast !== want.last_bin) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $write("ERROR: bin result mismatch: expected bin %0d level %0d ",
                           want.bin, want.level);
                    $write("first %0d count %0d last %0b, ",
                           want.first_col, want.col_count, want.last_bin);
                    $display("got bin %0d level %0d first %0d count %0d last %0b",
                             tdata[5:0], tdata[9:6], tdata[16:10], tdata[18:17], tlast);
                end
            end
        endfunction

        function int pending();
            return expected_bars.size();
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [sbld_pkg::IN_TDATA_W-1:0]     s_tdata;    // [15:0] energy
    logic                                s_tlast;    // last_value
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [sbld_pkg::OUT_TDATA_W-1:0]    m_tdata;    // [5:0] bin_index, [9:6] level,
                                                     // [16:10] first_column,
                                                     // [18:17] column_count, [23:19] zero
    logic                                m_tlast;    // last_bin
    logic                                cfg_we;
    logic [sbld_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [sbld_pkg::CFG_W-1:0]          cfg_wdata;

    bar_level_scoreboard sb;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    int  hold_left     = 0;
    bit  hold_armed    = 1'b0;
    int  quiet_cycles  = 0;

    spectrum_bar_level_display uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitors: note accepted inputs and check accepted results at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // Watchdog: end the run after too many cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once armed.
    always @(negedge aclk) begin
        if (hold_armed && m_tvalid) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one energy value and wait until the transaction is accepted.
    task automatic push_value(input logic [sbld_pkg::ENERGY_W-1:0] energy, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= energy;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    function automatic logic [sbld_pkg::ENERGY_W-1:0] pick_energy();
        case ($urandom_range(0, 19))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom_range(0, 4095)) - 16'd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_run_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 12);
            4, 5, 6:    return $urandom_range(30, NB * 2);
            7, 8:       return $urandom_range(NB * 2, NB * 3 + 5);
            default:    return NB;
        endcase
    endfunction

    task automatic send_run(input int len);
        for (int n = 0; n < len; n++) push_value(pick_energy(), n == len - 1);
    endtask

    // Drop valid, wait for every expected result and let the block settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_register(input logic [sbld_pkg::CFG_ADDR_W-1:0] idx,
                                input logic [sbld_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.write_register(idx, value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_levels(input logic [15:0] fl, input logic [15:0] ce);
        set_register(sbld_pkg::CFG_LEVEL_FLOOR, fl);
        set_register(sbld_pkg::CFG_LEVEL_CEILING, ce);
    endtask

    // Random floor and ceiling: wide, narrow near zero, default, equal, or inverted.
    task automatic pick_levels();
        logic [15:0] fl;
        logic [15:0] ce;
        case ($urandom_range(0, 4))
            0: begin
                fl = 16'($urandom);
                ce = 16'($urandom);
            end
            1: begin
                fl = 16'($urandom_range(0, 600)) - 16'd300;
                ce = fl + 16'($urandom_range(1, 600));
            end
            2: begin
                fl = sbld_pkg::FLOOR_RESET;
                ce = sbld_pkg::CEILING_RESET;
            end
            3: begin
                fl = 16'($urandom);
                ce = fl;
            end
            default: begin
                fl = 16'($urandom_range(0, 32767));
                ce = fl - 16'($urandom_range(1, 32767));
            end
        endcase
        set_levels(fl, ce);
    endtask

    // One phase of random runs under a given idling profile.
    task automatic random_phase(input int send_pct, input int recv_pct, input int item_goal,
                                input bit arm_hold);
        int sent;
        int len;
        wait_idle();
        pick_levels();
        @(posedge aclk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        hold_armed    = arm_hold;
        sent          = 0;
        while (sent < item_goal) begin
            len = pick_run_length();
            if (len > item_goal - sent) len = item_goal - sent;
            send_run(len);
            sent += len;
        end
    endtask

    initial begin
        logic [15:0] v;
        int          b;
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // The first frame's results meet a long receiver hold-off while the next
        // value is already on offer.
        hold_armed = 1'b1;

        // One full frame with field extremes, ending exactly on the frame boundary.
        for (int n = 0; n < NB; n++) begin
            case (n)
                0:       v = 16'h7FFF;
                1:       v = 16'h8000;
                2:       v = 16'h0000;
                3:       v = 16'hFFFF;
                4:       v = 16'h0001;
                default: v = pick_energy();
            endcase
            push_value(v, n == NB - 1);
        end
        // A run of one value: only bin 0 is overwritten, the rest keep their sums.
        push_value(16'h7FFF, 1'b1);

        // Widest possible range.
        wait_idle();
        set_levels(16'h8000, 16'h7FFF);
        send_run(10);

        // Ceiling equal to floor.
        wait_idle();
        set_levels(16'h0000, 16'h0000);
        push_value(16'h7FFF, 1'b0);
        push_value(16'h0000, 1'b0);
        push_value(16'h8000, 1'b1);

        // Ceiling below floor.
        wait_idle();
        set_levels(16'h7FFF, 16'h8000);
        push_value(16'h8000, 1'b0);
        push_value(16'h7FFF, 1'b1);

        // Run past a frame boundary: the second frame adds to the first.
        wait_idle();
        set_levels(sbld_pkg::FLOOR_RESET, sbld_pkg::CEILING_RESET);
        for (int n = 0; n < CROSS_RUN; n++) begin
            b = n % NB;
            case (b % 3)
                0:       v = 16'h7FFF;
                1:       v = 16'h8000;
                default: v = pick_energy();
            endcase
            push_value(v, n == CROSS_RUN - 1);
        end

        // Random runs under each idling profile.
        random_phase(0, 0, PHASE_ITEMS, 1'b0);
        random_phase(69, 0, PHASE_ITEMS, 1'b0);
        random_phase(0, 69, PHASE_ITEMS, 1'b0);
        random_phase(29, 29, PHASE_ITEMS, 1'b0);

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: spectrum_bar_level_display.f
rtl/core/sbld_pkg.sv
rtl/core/sbld_level_unit.sv
rtl/core/spectrum_bar_level_display.sv
sim/tb_spectrum_bar_level_display.sv
